### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the ADC-to-ASCII core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

### rtl/core/adcasc_pkg.sv
// ----------------------------------------------------------------------------
// adcasc_pkg
// Widths, constants, microcode table and shared types of the ADC-to-ASCII core.
// ----------------------------------------------------------------------------
package adcasc_pkg;

   // Field and register widths
   localparam int SAMPLE_W = 12;
   localparam int REF_W    = 16;
   localparam int FS_W     = 16;
   localparam int GAIN_W   = 16;
   localparam int OFS_W    = 24;
   localparam int CSR_W    = 24;
   localparam int CSR_IDX_W = 2;
   localparam int CHAR_W   = 6;
   localparam int VALUE_W  = 16;
   localparam int DIGIT_W  = 4;

   // Divider: dividend is the reading times the reference
   localparam int DIV_W     = REF_W + SAMPLE_W;
   localparam int DIVISOR_W = FS_W;
   localparam int DIV_STEPS = DIV_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);
   localparam int PROD_W    = GAIN_W + DIV_W;
   localparam int DIFF_W    = PROD_W + 1;

   // Register reset values
   localparam logic [REF_W-1:0]  REF_RESET  = REF_W'(3300);
   localparam logic [FS_W-1:0]   FS_RESET   = FS_W'(4095);
   localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(1000);
   localparam logic [OFS_W-1:0]  OFS_RESET  = OFS_W'(0);

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_REF  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_FS   = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_OFS  = CSR_IDX_W'(3);

   // Arithmetic constants
   localparam int MICRO_PER_MILLI = 1000;
   localparam int RADIX           = 10;
   localparam logic [VALUE_W-1:0] VALUE_MAX = '1;
   localparam logic [PROD_W-1:0]  SAT_LIMIT =
      PROD_W'((2 ** VALUE_W) * MICRO_PER_MILLI);
   // Exact divide by ten for every 16-bit value: (v * 52429) >> 19
   localparam logic [VALUE_W-1:0] RECIP_TEN   = VALUE_W'(52429);
   localparam int                 RECIP_SHIFT = 19;
   // Exact divide by one thousand below the saturation limit (< 2**26):
   // (v * 68719477) >> 36
   localparam int MILLI_IN_W    = 26;
   localparam int MILLI_RECIP_W = 27;
   localparam int MILLI_SHIFT   = 36;
   localparam int SCALE_W       = MILLI_IN_W + MILLI_RECIP_W;
   localparam logic [MILLI_RECIP_W-1:0] MILLI_RECIP = MILLI_RECIP_W'(68719477);
   localparam logic [CHAR_W-1:0]  ASCII_ZERO  = CHAR_W'(48);
   localparam logic [CHAR_W-1:0]  ASCII_NINE  = CHAR_W'(57);

   // Digit count
   localparam int MAX_DIGITS = 5;
   localparam int MIN_DIGITS = 4;
   localparam int MIN_DIGITS_EFF =
      (MIN_DIGITS > MAX_DIGITS) ? MAX_DIGITS : ((MIN_DIGITS < 1) ? 1 : MIN_DIGITS);
   localparam int DIG_IDX_W = $clog2(MAX_DIGITS);

   // Microcode field codes
   localparam int STEP_W = 4;
   localparam int OP_W   = 4;
   localparam int HOLD_W = 3;
   localparam int JMP_W  = 2;

   localparam logic [OP_W-1:0] OP_NOP        = OP_W'(0);
   localparam logic [OP_W-1:0] OP_ACCEPT     = OP_W'(1);
   localparam logic [OP_W-1:0] OP_DIV1_LOAD  = OP_W'(2);
   localparam logic [OP_W-1:0] OP_DIV_STEP   = OP_W'(3);
   localparam logic [OP_W-1:0] OP_GAIN_MUL   = OP_W'(4);
   localparam logic [OP_W-1:0] OP_OFFSET_SUB = OP_W'(5);
   localparam logic [OP_W-1:0] OP_CLAMP      = OP_W'(6);
   localparam logic [OP_W-1:0] OP_QUOT_TAKE  = OP_W'(7);
   localparam logic [OP_W-1:0] OP_DIGIT      = OP_W'(8);
   localparam logic [OP_W-1:0] OP_COUNT      = OP_W'(9);
   localparam logic [OP_W-1:0] OP_EMIT       = OP_W'(10);
   localparam logic [OP_W-1:0] OP_SCALE_MUL  = OP_W'(11);

   localparam logic [HOLD_W-1:0] HOLD_NONE   = HOLD_W'(0);
   localparam logic [HOLD_W-1:0] HOLD_NO_REQ = HOLD_W'(1);
   localparam logic [HOLD_W-1:0] HOLD_DIV    = HOLD_W'(2);
   localparam logic [HOLD_W-1:0] HOLD_DIGIT  = HOLD_W'(3);
   localparam logic [HOLD_W-1:0] HOLD_EMIT   = HOLD_W'(4);

   localparam logic [JMP_W-1:0] JMP_NONE   = JMP_W'(0);
   localparam logic [JMP_W-1:0] JMP_ALWAYS = JMP_W'(1);
   localparam logic [JMP_W-1:0] JMP_BYPASS = JMP_W'(2);

   // Program addresses
   localparam logic [STEP_W-1:0] STEP_IDLE  = STEP_W'(0);
   localparam logic [STEP_W-1:0] STEP_LOAD  = STEP_W'(1);
   localparam logic [STEP_W-1:0] STEP_DIV_A = STEP_W'(2);
   localparam logic [STEP_W-1:0] STEP_GAIN  = STEP_W'(3);
   localparam logic [STEP_W-1:0] STEP_SUB   = STEP_W'(4);
   localparam logic [STEP_W-1:0] STEP_CLAMP = STEP_W'(5);
   localparam logic [STEP_W-1:0] STEP_SCALE = STEP_W'(6);
   localparam logic [STEP_W-1:0] STEP_TAKE  = STEP_W'(7);
   localparam logic [STEP_W-1:0] STEP_DIGIT = STEP_W'(8);
   localparam logic [STEP_W-1:0] STEP_COUNT = STEP_W'(9);
   localparam logic [STEP_W-1:0] STEP_EMIT  = STEP_W'(10);

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [HOLD_W-1:0] hold;
      logic [JMP_W-1:0]  jump;
      logic [STEP_W-1:0] target;
   } ucode_type;

   // Divider commands from the sequencer
   typedef struct packed {
      logic load;
      logic step;
   } div_cmd_type;

   // Control store: one word per program step
   function automatic ucode_type ucode_rom(input logic [STEP_W-1:0] addr);
      ucode_type w;
      w = '{op: OP_NOP, hold: HOLD_NONE, jump: JMP_ALWAYS, target: STEP_IDLE};
      unique case (addr)
         STEP_IDLE:  w = '{op: OP_ACCEPT,     hold: HOLD_NO_REQ, jump: JMP_NONE,
                           target: STEP_IDLE};
         STEP_LOAD:  w = '{op: OP_DIV1_LOAD,  hold: HOLD_NONE,   jump: JMP_NONE,
                           target: STEP_IDLE};
         STEP_DIV_A: w = '{op: OP_DIV_STEP,   hold: HOLD_DIV,    jump: JMP_NONE,
                           target: STEP_IDLE};
         STEP_GAIN:  w = '{op: OP_GAIN_MUL,   hold: HOLD_NONE,   jump: JMP_NONE,
                           target: STEP_IDLE};
         STEP_SUB:   w = '{op: OP_OFFSET_SUB, hold: HOLD_NONE,   jump: JMP_NONE,
                           target: STEP_IDLE};
         STEP_CLAMP: w = '{op: OP_CLAMP,      hold: HOLD_NONE,   jump: JMP_BYPASS,
                           target: STEP_DIGIT};
         STEP_SCALE: w = '{op: OP_SCALE_MUL,  hold: HOLD_NONE,   jump: JMP_NONE,
                           target: STEP_IDLE};
         STEP_TAKE:  w = '{op: OP_QUOT_TAKE,  hold: HOLD_NONE,   jump: JMP_NONE,
                           target: STEP_IDLE};
         STEP_DIGIT: w = '{op: OP_DIGIT,      hold: HOLD_DIGIT,  jump: JMP_NONE,
                           target: STEP_IDLE};
         STEP_COUNT: w = '{op: OP_COUNT,      hold: HOLD_NONE,   jump: JMP_NONE,
                           target: STEP_IDLE};
         STEP_EMIT:  w = '{op: OP_EMIT,       hold: HOLD_EMIT,   jump: JMP_ALWAYS,
                           target: STEP_IDLE};
         default:    w = '{op: OP_NOP,        hold: HOLD_NONE,   jump: JMP_ALWAYS,
                           target: STEP_IDLE};
      endcase
      return w;
   endfunction

endpackage

### rtl/core/adcasc_req_if.sv
// ----------------------------------------------------------------------------
// adcasc_req_if
// Request channel: one raw converter reading per request.
// ----------------------------------------------------------------------------
interface adcasc_req_if;
   logic                              valid;
   logic                              ready;
   logic [adcasc_pkg::SAMPLE_W-1:0]   sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

### rtl/core/adcasc_rsp_if.sv
// ----------------------------------------------------------------------------
// adcasc_rsp_if
// Result channel: one ASCII digit per transfer, last digit flagged.
// ----------------------------------------------------------------------------
interface adcasc_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [adcasc_pkg::CHAR_W-1:0]     digit_char;
   logic                              last_char;

   modport source (output valid, output digit_char, output last_char, input ready);
   modport sink   (input valid, input digit_char, input last_char, output ready);
endinterface

### rtl/core/adcasc_div.sv
// ----------------------------------------------------------------------------
// adcasc_div
// Radix-2 restoring divider, one quotient bit per step command.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module adcasc_div (
   input  logic                                clock,
   input  logic                                reset,
   input  adcasc_pkg::div_cmd_type             cmd,
   input  logic [adcasc_pkg::DIV_W-1:0]        dividend,
   input  logic [adcasc_pkg::DIVISOR_W-1:0]    divisor,
   output logic [adcasc_pkg::DIV_W-1:0]        quotient,
   output logic                                last
);

   logic [adcasc_pkg::DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [adcasc_pkg::DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [adcasc_pkg::DIV_W-1:0]      quo_ff, quo_in;
   logic [adcasc_pkg::DIVISOR_W-1:0]  dvs_ff, dvs_in;
   logic [adcasc_pkg::DIVISOR_W:0]    partial;
   logic [adcasc_pkg::DIVISOR_W+1:0]  trial;

   // Shift in the next dividend bit and try the subtraction
   assign partial = {rem_ff, quo_ff[adcasc_pkg::DIV_W-1]};
   assign trial   = {1'b0, partial} - {2'b00, dvs_ff};

   always_comb begin
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      dvs_in = dvs_ff;
      if (cmd.load) begin
         cnt_in = adcasc_pkg::DIV_CNT_W'(adcasc_pkg::DIV_STEPS);
         rem_in = '0;
         quo_in = dividend;
         dvs_in = divisor;
      end else if (cmd.step) begin
         cnt_in = cnt_ff - 1'b1;
         if (!trial[adcasc_pkg::DIVISOR_W+1]) begin
            rem_in = trial[adcasc_pkg::DIVISOR_W-1:0];
            quo_in = {quo_ff[adcasc_pkg::DIV_W-2:0], 1'b1};
         end else begin
            rem_in = partial[adcasc_pkg::DIVISOR_W-1:0];
            quo_in = {quo_ff[adcasc_pkg::DIV_W-2:0], 1'b0};
         end
      end
   end

   // Hold the step count under reset
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // Advance the working registers
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign quotient = quo_ff;
   assign last     = (cnt_ff == adcasc_pkg::DIV_CNT_W'(1));

   `ASSERT_IMPLY(a_step_needs_count, clock, reset, cmd.step, cnt_ff != '0)
   `ASSERT_NEXT(a_load_sets_count, clock, reset, cmd.load,
      cnt_ff == adcasc_pkg::DIV_CNT_W'(adcasc_pkg::DIV_STEPS))
   `ASSERT_NEXT(a_rem_below_divisor, clock, reset,
      cmd.step && last && (dvs_ff != '0), rem_ff < dvs_ff)

endmodule

### rtl/core/adc_millivolt_to_ascii_digits_top.sv
// After a request is taken the program loads the radix-2 divider, runs its 28-step
// pass, multiplies by the gain, subtracts the offset and clamps; it skips the scaling
// steps when the offset exceeds the gained value or the result saturates. It then
// sends N = 4 or 5 decimal digits and takes no new reading before the last digit
// is sent. Synchronous reset idles the sequencer and loads the default calibration
// registers.
// ----------------------------------------------------------------------------
// adc_millivolt_to_ascii_digits_top
// Microcoded converter from a raw ADC reading to calibrated decimal ASCII.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module adc_millivolt_to_ascii_digits_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [adcasc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [adcasc_pkg::CSR_W-1:0]         csr_wdata,
   adcasc_req_if.sink                           req_bus,
   adcasc_rsp_if.source                         rsp_bus
);

   // Calibration registers
   logic [adcasc_pkg::REF_W-1:0]   ref_ff, ref_in;
   logic [adcasc_pkg::FS_W-1:0]    fs_ff, fs_in;
   logic [adcasc_pkg::GAIN_W-1:0]  gain_ff, gain_in;
   logic [adcasc_pkg::OFS_W-1:0]   ofs_ff, ofs_in;

   // Sequencer
   logic [adcasc_pkg::STEP_W-1:0]  step_ff, step_in;
   adcasc_pkg::ucode_type          uc;
   logic                           hold_hit;
   logic                           jump_hit;
   logic                           bypass;

   // Datapath
   logic [adcasc_pkg::SAMPLE_W-1:0]  sample_ff, sample_in;
   logic [adcasc_pkg::DIV_W-1:0]     calib_ff, calib_in;
   logic [adcasc_pkg::PROD_W-1:0]    prod_ff, prod_in;
   logic [adcasc_pkg::DIFF_W-1:0]    diff_ff, diff_in;
   logic [adcasc_pkg::SCALE_W-1:0]   scale_ff, scale_in;
   logic [adcasc_pkg::VALUE_W-1:0]   value_ff, value_in;
   logic [adcasc_pkg::DIGIT_W-1:0]   digits_ff [adcasc_pkg::MAX_DIGITS];
   logic [adcasc_pkg::DIGIT_W-1:0]   digits_in [adcasc_pkg::MAX_DIGITS];
   logic [adcasc_pkg::DIG_IDX_W-1:0] dig_cnt_ff, dig_cnt_in;
   logic [adcasc_pkg::DIG_IDX_W-1:0] out_idx_ff, out_idx_in;
   logic [adcasc_pkg::DIG_IDX_W-1:0] top_idx;

   // Divide-by-ten helpers
   logic [2*adcasc_pkg::VALUE_W-1:0] recip_prod;
   logic [adcasc_pkg::VALUE_W-1:0]   tenth;
   logic [adcasc_pkg::DIGIT_W-1:0]   digit;

   // Divider connection
   adcasc_pkg::div_cmd_type              div_cmd;
   logic [adcasc_pkg::DIV_W-1:0]         div_dividend;
   logic [adcasc_pkg::DIVISOR_W-1:0]     div_divisor;
   logic [adcasc_pkg::DIV_W-1:0]         div_quotient;
   logic                                 div_last;

   logic req_take;
   logic rsp_take;

   adcasc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .cmd      (div_cmd),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quotient),
      .last     (div_last)
   );

   // Decode the current control word
   assign uc       = adcasc_pkg::ucode_rom(step_ff);
   assign req_take = req_bus.valid && req_bus.ready;
   assign rsp_take = rsp_bus.valid && rsp_bus.ready;

   // Skip the scaling steps when the offset wins or the value saturates
   assign bypass = diff_ff[adcasc_pkg::DIFF_W-1] ||
                   (diff_ff[adcasc_pkg::PROD_W-1:0] >= adcasc_pkg::SAT_LIMIT);

   // Divide by ten through the reciprocal
   assign recip_prod = (2*adcasc_pkg::VALUE_W)'(value_ff) *
                       (2*adcasc_pkg::VALUE_W)'(adcasc_pkg::RECIP_TEN);
   assign tenth = adcasc_pkg::VALUE_W'(recip_prod[2*adcasc_pkg::VALUE_W-1:adcasc_pkg::RECIP_SHIFT]);
   assign digit = adcasc_pkg::DIGIT_W'(value_ff -
                  tenth * adcasc_pkg::VALUE_W'(adcasc_pkg::RADIX));

   // Find the highest digit to send, padding to the minimum count
   always_comb begin
      top_idx = '0;
      for (int k = 0; k < adcasc_pkg::MAX_DIGITS; k++) begin
         if ((digits_ff[k] != '0) || (k < adcasc_pkg::MIN_DIGITS_EFF)) begin
            top_idx = adcasc_pkg::DIG_IDX_W'(k);
         end
      end
   end

   // Sequencer branch conditions
   always_comb begin
      case (uc.hold)
         adcasc_pkg::HOLD_NO_REQ: hold_hit = !req_bus.valid;
         adcasc_pkg::HOLD_DIV:    hold_hit = !div_last;
         adcasc_pkg::HOLD_DIGIT:  hold_hit =
            (dig_cnt_ff != adcasc_pkg::DIG_IDX_W'(adcasc_pkg::MAX_DIGITS - 1));
         adcasc_pkg::HOLD_EMIT:   hold_hit = !(rsp_bus.ready && (out_idx_ff == '0));
         default:                 hold_hit = 1'b0;
      endcase
      case (uc.jump)
         adcasc_pkg::JMP_ALWAYS: jump_hit = 1'b1;
         adcasc_pkg::JMP_BYPASS: jump_hit = bypass;
         default:                jump_hit = 1'b0;
      endcase
      if (hold_hit) begin
         step_in = step_ff;
      end else if (jump_hit) begin
         step_in = uc.target;
      end else begin
         step_in = step_ff + 1'b1;
      end
   end

   // Configuration writes
   always_comb begin
      ref_in  = ref_ff;
      fs_in   = fs_ff;
      gain_in = gain_ff;
      ofs_in  = ofs_ff;
      if (csr_we) begin
         unique case (csr_index)
            adcasc_pkg::CSR_REF:  ref_in  = csr_wdata[adcasc_pkg::REF_W-1:0];
            adcasc_pkg::CSR_FS:   fs_in   = csr_wdata[adcasc_pkg::FS_W-1:0];
            adcasc_pkg::CSR_GAIN: gain_in = csr_wdata[adcasc_pkg::GAIN_W-1:0];
            adcasc_pkg::CSR_OFS:  ofs_in  = csr_wdata[adcasc_pkg::OFS_W-1:0];
            default: ;
         endcase
      end
   end

   // Datapath operations, one per control word
   always_comb begin
      sample_in    = sample_ff;
      calib_in     = calib_ff;
      prod_in      = prod_ff;
      diff_in      = diff_ff;
      scale_in     = scale_ff;
      value_in     = value_ff;
      digits_in    = digits_ff;
      dig_cnt_in   = dig_cnt_ff;
      out_idx_in   = out_idx_ff;
      div_cmd      = '0;
      div_dividend = adcasc_pkg::DIV_W'(ref_ff) * adcasc_pkg::DIV_W'(sample_ff);
      div_divisor  = fs_ff;
      unique case (uc.op)
         adcasc_pkg::OP_ACCEPT: begin
            if (req_bus.valid) begin
               sample_in = req_bus.sample;
            end
         end
         adcasc_pkg::OP_DIV1_LOAD: begin
            div_cmd.load = 1'b1;
            dig_cnt_in   = '0;
         end
         adcasc_pkg::OP_DIV_STEP: begin
            div_cmd.step = 1'b1;
         end
         adcasc_pkg::OP_GAIN_MUL: begin
            calib_in = div_quotient;
            prod_in  = adcasc_pkg::PROD_W'(gain_ff) * adcasc_pkg::PROD_W'(div_quotient);
         end
         adcasc_pkg::OP_OFFSET_SUB: begin
            diff_in = {1'b0, prod_ff} - adcasc_pkg::DIFF_W'(ofs_ff);
         end
         adcasc_pkg::OP_CLAMP: begin
            // Offset above the gained value: fall back to raw millivolts
            if (diff_ff[adcasc_pkg::DIFF_W-1]) begin
               if (calib_ff > adcasc_pkg::DIV_W'(adcasc_pkg::VALUE_MAX)) begin
                  value_in = adcasc_pkg::VALUE_MAX;
               end else begin
                  value_in = calib_ff[adcasc_pkg::VALUE_W-1:0];
               end
            end else if (bypass) begin
               value_in = adcasc_pkg::VALUE_MAX;
            end
         end
         adcasc_pkg::OP_SCALE_MUL: begin
            // Divide by one thousand through the reciprocal
            scale_in = adcasc_pkg::SCALE_W'(diff_ff[adcasc_pkg::MILLI_IN_W-1:0]) *
                       adcasc_pkg::SCALE_W'(adcasc_pkg::MILLI_RECIP);
         end
         adcasc_pkg::OP_QUOT_TAKE: begin
            value_in = scale_ff[adcasc_pkg::MILLI_SHIFT+adcasc_pkg::VALUE_W-1:
                                adcasc_pkg::MILLI_SHIFT];
         end
         adcasc_pkg::OP_DIGIT: begin
            // Shift the new low digit in at the top; the first lands at index 0
            for (int k = 0; k < adcasc_pkg::MAX_DIGITS - 1; k++) begin
               digits_in[k] = digits_ff[k+1];
            end
            digits_in[adcasc_pkg::MAX_DIGITS-1] = digit;
            value_in   = tenth;
            dig_cnt_in = dig_cnt_ff + 1'b1;
         end
         adcasc_pkg::OP_COUNT: begin
            out_idx_in = top_idx;
         end
         adcasc_pkg::OP_EMIT: begin
            if (rsp_bus.ready && (out_idx_ff != '0)) begin
               out_idx_in = out_idx_ff - 1'b1;
            end
         end
         adcasc_pkg::OP_NOP: ;
         default: ;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff    <= adcasc_pkg::STEP_IDLE;
         ref_ff     <= adcasc_pkg::REF_RESET;
         fs_ff      <= adcasc_pkg::FS_RESET;
         gain_ff    <= adcasc_pkg::GAIN_RESET;
         ofs_ff     <= adcasc_pkg::OFS_RESET;
         dig_cnt_ff <= '0;
         out_idx_ff <= '0;
      end else begin
         step_ff    <= step_in;
         ref_ff     <= ref_in;
         fs_ff      <= fs_in;
         gain_ff    <= gain_in;
         ofs_ff     <= ofs_in;
         dig_cnt_ff <= dig_cnt_in;
         out_idx_ff <= out_idx_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      calib_ff  <= calib_in;
      prod_ff   <= prod_in;
      diff_ff   <= diff_in;
      scale_ff  <= scale_in;
      value_ff  <= value_in;
      digits_ff <= digits_in;
   end

   // Channel outputs
   assign req_bus.ready      = (uc.op == adcasc_pkg::OP_ACCEPT);
   assign rsp_bus.valid      = (uc.op == adcasc_pkg::OP_EMIT);
   assign rsp_bus.digit_char = adcasc_pkg::ASCII_ZERO +
                               adcasc_pkg::CHAR_W'(digits_ff[out_idx_ff]);
   assign rsp_bus.last_char  = (out_idx_ff == '0);

   `ASSERT_IMPLY(a_one_reading_at_a_time, clock, reset, rsp_bus.valid, !req_bus.ready)
   `ASSERT_NEXT(a_idle_after_last, clock, reset, rsp_take && rsp_bus.last_char,
      req_bus.ready)
   `ASSERT_IMPLY(a_char_is_digit, clock, reset, rsp_bus.valid,
      (rsp_bus.digit_char >= adcasc_pkg::ASCII_ZERO) &&
      (rsp_bus.digit_char <= adcasc_pkg::ASCII_NINE))
   `ASSERT_NEXT(a_request_starts_program, clock, reset, req_take,
      step_ff == adcasc_pkg::STEP_LOAD)

endmodule
